### rtl/core/p2g_pkg.sv
// ----------------------------------------------------------------------------
// p2g_pkg
// Shared widths, status codes and types for the pixel to ground plane mapper.
// ----------------------------------------------------------------------------
package p2g_pkg;

   // pixel and fixed point format
   localparam int PIXEL_BITS = 12;
   localparam int FRAC_BITS  = 16;
   localparam int COEF_W     = 32;
   localparam int QUO_W      = 32;

   // coefficient registers
   localparam int NUM_COEF   = 8;
   localparam int CSR_IDX_W  = 8;

   // signed product of a coefficient and a zero-extended pixel coordinate
   localparam int PROD_W     = COEF_W + PIXEL_BITS + 1;
   // sum of three terms, with headroom
   localparam int SUM_W      = PROD_W + 2;
   // magnitude of a sum
   localparam int MAG_W      = SUM_W;

   // one quotient bit per divider stage
   localparam int DIV_STEPS  = QUO_W;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] IDX_XU = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] IDX_XV = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] IDX_XC = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] IDX_YU = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] IDX_YV = CSR_IDX_W'(4);
   localparam logic [CSR_IDX_W-1:0] IDX_YC = CSR_IDX_W'(5);
   localparam logic [CSR_IDX_W-1:0] IDX_WU = CSR_IDX_W'(6);
   localparam logic [CSR_IDX_W-1:0] IDX_WV = CSR_IDX_W'(7);

   // result status codes
   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_ZERO = 2'd1,
      ST_SAT  = 2'd2
   } status_type;

   localparam logic [COEF_W-1:0] ONE_FIX = COEF_W'(1) << FRAC_BITS;
   localparam logic [QUO_W-1:0]  POS_MAX = {1'b0, {(QUO_W-1){1'b1}}};
   localparam logic [QUO_W-1:0]  NEG_MIN = {1'b1, {(QUO_W-1){1'b0}}};

endpackage

### rtl/core/p2g_div.sv
// ----------------------------------------------------------------------------
// p2g_div
// Pipelined restoring divider: one quotient bit per stage, fixed point
// quotient of two magnitudes with FRAC_BITS fraction bits, plus overflow flag.
// ----------------------------------------------------------------------------
module p2g_div
   import p2g_pkg::*;
(
   input  logic             clock,
   input  logic             advance,
   input  logic [MAG_W-1:0] num_mag,
   input  logic [MAG_W-1:0] den_mag,
   output logic [QUO_W-1:0] quo,
   output logic             ovf
);

   typedef struct packed {
      logic             qbit;
      logic [MAG_W-1:0] rem;
   } step_type;

   // one compare and subtract
   function automatic step_type div_step(input logic [MAG_W-1:0] rem,
                                         input logic [MAG_W-1:0] den,
                                         input logic             bit_in);
      logic [MAG_W:0] trial;
      step_type       res;
      trial = {rem, bit_in};
      if (trial >= {1'b0, den}) begin
         res.qbit = 1'b1;
         res.rem  = MAG_W'(trial - {1'b0, den});
      end else begin
         res.qbit = 1'b0;
         res.rem  = trial[MAG_W-1:0];
      end
      return res;
   endfunction

   logic [MAG_W-1:0] rem_ff [DIV_STEPS];
   logic [MAG_W-1:0] rem_in [DIV_STEPS];
   logic [QUO_W-1:0] lo_ff  [DIV_STEPS];
   logic [QUO_W-1:0] lo_in  [DIV_STEPS];
   logic [QUO_W-1:0] quo_ff [DIV_STEPS];
   logic [QUO_W-1:0] quo_in [DIV_STEPS];
   logic [MAG_W-1:0] den_ff [DIV_STEPS];
   logic             ovf_ff [DIV_STEPS];
   logic             ovf_in [DIV_STEPS];

   logic [MAG_W-1:0] rem0;
   logic [QUO_W-1:0] lo0;
   step_type         st0;

   // dividend is num * 2^FRAC_BITS: high part seeds the remainder
   assign rem0 = num_mag >> (QUO_W - FRAC_BITS);
   assign lo0  = {num_mag[QUO_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
   assign st0  = div_step(rem0, den_mag, lo0[QUO_W-1]);

   // per-stage next values
   always_comb begin
      step_type st;
      rem_in[0] = st0.rem;
      lo_in[0]  = lo0 << 1;
      quo_in[0] = {{(QUO_W-1){1'b0}}, st0.qbit};
      ovf_in[0] = (rem0 >= den_mag);
      for (int k = 1; k < DIV_STEPS; k++) begin
         st        = div_step(rem_ff[k-1], den_ff[k-1], lo_ff[k-1][QUO_W-1]);
         rem_in[k] = st.rem;
         lo_in[k]  = lo_ff[k-1] << 1;
         quo_in[k] = {quo_ff[k-1][QUO_W-2:0], st.qbit};
         ovf_in[k] = ovf_ff[k-1];
      end
   end

   // stage registers
   always_ff @(posedge clock) begin
      if (advance) begin
         den_ff[0] <= den_mag;
         for (int k = 0; k < DIV_STEPS; k++) begin
            rem_ff[k] <= rem_in[k];
            lo_ff[k]  <= lo_in[k];
            quo_ff[k] <= quo_in[k];
            ovf_ff[k] <= ovf_in[k];
         end
         for (int k = 1; k < DIV_STEPS; k++) begin
            den_ff[k] <= den_ff[k-1];
         end
      end
   end

   assign quo = quo_ff[DIV_STEPS-1];
   assign ovf = ovf_ff[DIV_STEPS-1];

endmodule

### rtl/core/pixel_to_ground_plane_map.sv
// ----------------------------------------------------------------------------
// pixel_to_ground_plane_map
// Maps an image pixel onto the ground plane through a loaded homography.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/stall    | pixel_u, pixel_v
//  rsp     | out       | rsp_valid/stall    | world_x, world_y, map_status
//  csr     | in        | csr_write          | csr_index, csr_data
//
//  One beat in and one beat out per cycle while the output is not stalled;
//  DIV_STEPS + 4 register stages (multiply, sum, magnitude, 32 divider
//  stages, saturate to output register).
//  The quotient comes from two 32-stage divider pipelines, one bit per stage.
//  Synchronous reset clears the valid bits and loads the identity homography.
//  A stalled output beat freezes the whole pipeline; req_stall follows it.
// ----------------------------------------------------------------------------
module pixel_to_ground_plane_map
   import p2g_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [PIXEL_BITS-1:0] req_pixel_u,
   input  logic [PIXEL_BITS-1:0] req_pixel_v,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic signed [QUO_W-1:0] rsp_world_x,
   output logic signed [QUO_W-1:0] rsp_world_y,
   output logic [1:0]            rsp_map_status,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [COEF_W-1:0]     csr_data
);

   typedef struct packed {
      logic             sat;
      logic [QUO_W-1:0] value;
   } fix_type;

   // signed clamp of a quotient magnitude
   function automatic fix_type fix_result(input logic ovf, input logic neg,
                                          input logic [QUO_W-1:0] q);
      fix_type res;
      if (ovf) begin
         res.sat   = 1'b1;
         res.value = neg ? NEG_MIN : POS_MAX;
      end else if (neg) begin
         res.sat   = (q > NEG_MIN);
         res.value = res.sat ? NEG_MIN : QUO_W'(-q);
      end else begin
         res.sat   = (q > POS_MAX);
         res.value = res.sat ? POS_MAX : q;
      end
      return res;
   endfunction

   logic advance;

   // coefficient registers
   logic signed [COEF_W-1:0] coef_xu_ff, coef_xv_ff, coef_xc_ff;
   logic signed [COEF_W-1:0] coef_yu_ff, coef_yv_ff, coef_yc_ff;
   logic signed [COEF_W-1:0] coef_wu_ff, coef_wv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_xu_ff <= ONE_FIX;
         coef_xv_ff <= '0;
         coef_xc_ff <= '0;
         coef_yu_ff <= '0;
         coef_yv_ff <= ONE_FIX;
         coef_yc_ff <= '0;
         coef_wu_ff <= '0;
         coef_wv_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            IDX_XU:  coef_xu_ff <= csr_data;
            IDX_XV:  coef_xv_ff <= csr_data;
            IDX_XC:  coef_xc_ff <= csr_data;
            IDX_YU:  coef_yu_ff <= csr_data;
            IDX_YV:  coef_yv_ff <= csr_data;
            IDX_YC:  coef_yc_ff <= csr_data;
            IDX_WU:  coef_wu_ff <= csr_data;
            IDX_WV:  coef_wv_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // pipeline moves unless the output beat is held
   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;

   // stage 1: products
   logic signed [PIXEL_BITS:0] u_s, v_s;
   logic signed [PROD_W-1:0] p_xu_ff, p_xv_ff, p_yu_ff, p_yv_ff, p_wu_ff, p_wv_ff;
   logic v1_ff;

   assign u_s = signed'({1'b0, req_pixel_u});
   assign v_s = signed'({1'b0, req_pixel_v});

   always_ff @(posedge clock) begin
      if (advance) begin
         p_xu_ff <= PROD_W'(coef_xu_ff * u_s);
         p_xv_ff <= PROD_W'(coef_xv_ff * v_s);
         p_yu_ff <= PROD_W'(coef_yu_ff * u_s);
         p_yv_ff <= PROD_W'(coef_yv_ff * v_s);
         p_wu_ff <= PROD_W'(coef_wu_ff * u_s);
         p_wv_ff <= PROD_W'(coef_wv_ff * v_s);
      end
   end

   // stage 2: dot products
   logic signed [SUM_W-1:0] nx_ff, ny_ff, w_ff;
   logic v2_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         nx_ff <= SUM_W'(p_xu_ff) + SUM_W'(p_xv_ff) + SUM_W'(coef_xc_ff);
         ny_ff <= SUM_W'(p_yu_ff) + SUM_W'(p_yv_ff) + SUM_W'(coef_yc_ff);
         w_ff  <= SUM_W'(p_wu_ff) + SUM_W'(p_wv_ff) + (SUM_W'(1) << FRAC_BITS);
      end
   end

   // stage 3: magnitudes, result signs and zero denominator
   logic [MAG_W-1:0] mag_nx_ff, mag_ny_ff, mag_w_ff;
   logic neg_x_in, neg_y_in, zero_in;
   logic v3_ff;

   assign neg_x_in = nx_ff[SUM_W-1] != w_ff[SUM_W-1];
   assign neg_y_in = ny_ff[SUM_W-1] != w_ff[SUM_W-1];
   assign zero_in  = (w_ff == '0);

   logic neg_x_ff [DIV_STEPS+1];
   logic neg_y_ff [DIV_STEPS+1];
   logic zero_ff  [DIV_STEPS+1];
   logic vd_ff    [DIV_STEPS];

   always_ff @(posedge clock) begin
      if (advance) begin
         mag_nx_ff <= nx_ff[SUM_W-1] ? MAG_W'(-nx_ff) : MAG_W'(nx_ff);
         mag_ny_ff <= ny_ff[SUM_W-1] ? MAG_W'(-ny_ff) : MAG_W'(ny_ff);
         mag_w_ff  <= w_ff[SUM_W-1]  ? MAG_W'(-w_ff)  : MAG_W'(w_ff);
         neg_x_ff[0] <= neg_x_in;
         neg_y_ff[0] <= neg_y_in;
         zero_ff[0]  <= zero_in;
         for (int k = 1; k <= DIV_STEPS; k++) begin
            neg_x_ff[k] <= neg_x_ff[k-1];
            neg_y_ff[k] <= neg_y_ff[k-1];
            zero_ff[k]  <= zero_ff[k-1];
         end
      end
   end

   // stages 4 to DIV_STEPS+3: dividers
   logic [QUO_W-1:0] quo_x, quo_y;
   logic ovf_x, ovf_y;

   p2g_div u_div_x (
      .clock   (clock),
      .advance (advance),
      .num_mag (mag_nx_ff),
      .den_mag (mag_w_ff),
      .quo     (quo_x),
      .ovf     (ovf_x)
   );

   p2g_div u_div_y (
      .clock   (clock),
      .advance (advance),
      .num_mag (mag_ny_ff),
      .den_mag (mag_w_ff),
      .quo     (quo_y),
      .ovf     (ovf_y)
   );

   // valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         for (int k = 0; k < DIV_STEPS; k++) begin
            vd_ff[k] <= 1'b0;
         end
         rsp_valid <= 1'b0;
      end else if (advance) begin
         v1_ff    <= req_valid;
         v2_ff    <= v1_ff;
         v3_ff    <= v2_ff;
         vd_ff[0] <= v3_ff;
         for (int k = 1; k < DIV_STEPS; k++) begin
            vd_ff[k] <= vd_ff[k-1];
         end
         rsp_valid <= vd_ff[DIV_STEPS-1];
      end
   end

   // final stage: sign, clamp and status into the output register
   fix_type fx, fy;

   assign fx = fix_result(ovf_x, neg_x_ff[DIV_STEPS], quo_x);
   assign fy = fix_result(ovf_y, neg_y_ff[DIV_STEPS], quo_y);

   always_ff @(posedge clock) begin
      if (advance) begin
         if (zero_ff[DIV_STEPS]) begin
            rsp_world_x    <= '0;
            rsp_world_y    <= '0;
            rsp_map_status <= ST_ZERO;
         end else begin
            rsp_world_x    <= fx.value;
            rsp_world_y    <= fy.value;
            rsp_map_status <= (fx.sat || fy.sat) ? ST_SAT : ST_OK;
         end
      end
   end

endmodule

### rtl/core/p2g_checker.sv
// ----------------------------------------------------------------------------
// p2g_checker
// Port-level checks for the pixel to ground plane mapper, bound to the top.
// ----------------------------------------------------------------------------
module p2g_checker
   import p2g_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [QUO_W-1:0]      rsp_world_x,
   input logic [QUO_W-1:0]      rsp_world_y,
   input logic [1:0]            rsp_map_status
);

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat right after reset");

   // input is only held back by a held output beat
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without output back-pressure");

   // a held result beat keeps its payload
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_world_x)
         && $stable(rsp_world_y) && $stable(rsp_map_status)))
      else $error("held result beat changed");

   // zero denominator gives zero coordinates
   a_zero_out: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_map_status == ST_ZERO) |->
         (rsp_world_x == '0 && rsp_world_y == '0))
      else $error("zero denominator with nonzero result");

   // status code stays in range
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_map_status == ST_OK || rsp_map_status == ST_ZERO
         || rsp_map_status == ST_SAT))
      else $error("unknown status code");

endmodule

bind pixel_to_ground_plane_map p2g_checker u_p2g_checker (
   .clock          (clock),
   .reset          (reset),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_world_x    (rsp_world_x),
   .rsp_world_y    (rsp_world_y),
   .rsp_map_status (rsp_map_status)
);

### tb/ground_map_checker.sv
// ----------------------------------------------------------------------------
// ground_map_checker
// Watches the pixel and result channels and the coefficient writes, predicts
// each mapped ground point from a private copy of the homography and compares
// every result beat field by field, in order.
// ----------------------------------------------------------------------------
module ground_map_checker
   import p2g_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_stall,
   input  logic [PIXEL_BITS-1:0]   req_pixel_u,
   input  logic [PIXEL_BITS-1:0]   req_pixel_v,
   input  logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  logic signed [QUO_W-1:0] rsp_world_x,
   input  logic signed [QUO_W-1:0] rsp_world_y,
   input  logic [1:0]              rsp_map_status,
   input  logic                    csr_write,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [COEF_W-1:0]       csr_data,
   output int                      fail_count,
   output int                      pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SEL_W = $clog2(NUM_COEF);

   typedef struct packed {
      logic [QUO_W-1:0] x;
      logic [QUO_W-1:0] y;
      logic [1:0]       status;
   } ground_point_type;

   logic signed [COEF_W-1:0] homog [NUM_COEF];
   ground_point_type         point_q [$];

   // truncating fixed point divide with saturation
   function automatic logic [QUO_W-1:0] ground_div(input longint num, input longint den,
                                                   inout logic sat);
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] q;
      logic [63:0] r;
      logic        neg;
      a   = (num < 0) ? 64'(-num) : 64'(num);
      b   = (den < 0) ? 64'(-den) : 64'(den);
      neg = (num < 0) != (den < 0);
      q   = a / b;
      r   = a % b;
      if ((q >> (32 - FRAC_BITS)) != 0) begin
         sat = 1'b1;
         return neg ? NEG_MIN : POS_MAX;
      end
      for (int i = 0; i < FRAC_BITS; i++) begin
         r = r << 1;
         q = q << 1;
         if (r >= b) begin
            r = r - b;
            q = q | 64'd1;
         end
      end
      if (neg) begin
         if (q > 64'h8000_0000) begin
            sat = 1'b1;
            return NEG_MIN;
         end
         return QUO_W'(-q);
      end
      if (q > 64'h7FFF_FFFF) begin
         sat = 1'b1;
         return POS_MAX;
      end
      return QUO_W'(q);
   endfunction

   function automatic ground_point_type map_pixel(input logic [PIXEL_BITS-1:0] pu,
                                                  input logic [PIXEL_BITS-1:0] pv);
      longint           u;
      longint           v;
      longint           nx;
      longint           ny;
      longint           w;
      logic             sat;
      ground_point_type pt;
      u   = longint'(pu);
      v   = longint'(pv);
      nx  = longint'(homog[SEL_W'(IDX_XU)]) * u + longint'(homog[SEL_W'(IDX_XV)]) * v
            + longint'(homog[SEL_W'(IDX_XC)]);
      ny  = longint'(homog[SEL_W'(IDX_YU)]) * u + longint'(homog[SEL_W'(IDX_YV)]) * v
            + longint'(homog[SEL_W'(IDX_YC)]);
      w   = longint'(homog[SEL_W'(IDX_WU)]) * u + longint'(homog[SEL_W'(IDX_WV)]) * v
            + (longint'(1) << FRAC_BITS);
      sat = 1'b0;
      if (w == 0) begin
         pt.x      = '0;
         pt.y      = '0;
         pt.status = ST_ZERO;
         return pt;
      end
      pt.x      = ground_div(nx, w, sat);
      pt.y      = ground_div(ny, w, sat);
      pt.status = sat ? ST_SAT : ST_OK;
      return pt;
   endfunction

   // track writes, predict on pixel beats, compare on result beats
   always @(posedge clock) begin
      ground_point_type want;
      int               errs;
      errs = 0;
      if (reset) begin
         homog <= '{ONE_FIX, '0, '0, '0, ONE_FIX, '0, '0, '0};
         point_q.delete();
         fail_count <= 0;
         pending    <= 0;
      end else begin
         if (csr_write && csr_index < NUM_COEF) homog[SEL_W'(csr_index)] <= csr_data;
         if (req_valid && !req_stall)
            point_q.insert(point_q.size(), map_pixel(req_pixel_u, req_pixel_v));
         if (rsp_valid && !rsp_stall) begin
            if (point_q.size() == 0) begin
               $error("unexpected result beat");
               errs++;
            end else begin
               want = point_q.pop_front();
               if (rsp_world_x !== want.x) begin
                  $error("world_x expected %h actual %h", want.x, rsp_world_x);
                  errs++;
               end
               if (rsp_world_y !== want.y) begin
                  $error("world_y expected %h actual %h", want.y, rsp_world_y);
                  errs++;
               end
               if (rsp_map_status !== want.status) begin
                  $error("map_status expected %0d actual %0d", want.status, rsp_map_status);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
         pending    <= point_q.size();
      end
   end

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives pixel beats through the ground plane mapper under several homography
// settings with random idling on both sides; the checker does the comparison.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import p2g_pkg::*;

   localparam int LATENCY = DIV_STEPS + 4;
   localparam int LIMIT   = 400000;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic [PIXEL_BITS-1:0]   req_pixel_u;
   logic [PIXEL_BITS-1:0]   req_pixel_v;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic signed [QUO_W-1:0] rsp_world_x;
   logic signed [QUO_W-1:0] rsp_world_y;
   logic [1:0]              rsp_map_status;
   logic                    csr_write;
   logic [CSR_IDX_W-1:0]    csr_index;
   logic [COEF_W-1:0]       csr_data;
   int                      fail_count;
   int                      pending;
   int                      cycle_count;
   bit                      busy_mode;

   pixel_to_ground_plane_map u_dut (.*);

   ground_map_checker u_checker (.*);

   // clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // result side back pressure
   always @(negedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= busy_mode ? 1'b0 : ($urandom_range(99) < 35);
   end

   task automatic write_coef(input logic [CSR_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   // one pixel beat, with random idle cycles ahead of it
   task automatic send_pixel(input logic [PIXEL_BITS-1:0] pu, input logic [PIXEL_BITS-1:0] pv);
      while (!busy_mode && $urandom_range(99) < 35) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_pixel_u <= pu;
      req_pixel_v <= pv;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   function automatic logic [COEF_W-1:0] rand_coef(input int kind);
      case (kind)
         0: return $urandom;
         1: return COEF_W'(int'($urandom_range(131072)) - 65536);
         2: return COEF_W'(int'($urandom_range(64)) - 32);
         default: return $urandom_range(1) ? POS_MAX : NEG_MIN;
      endcase
   endfunction

   initial begin
      logic [COEF_W-1:0] c;
      cycle_count = 0;
      busy_mode   = 1'b0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_pixel_u = '0;
      req_pixel_v = '0;
      rsp_stall   = 1'b0;
      csr_write   = 1'b0;
      csr_index   = '0;
      csr_data    = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // identity homography straight out of reset, extremes of the pixel range
      send_pixel('0, '0);
      send_pixel('1, '1);
      send_pixel('1, '0);
      send_pixel('0, '1);
      send_pixel(12'h555, 12'hAAA);
      drain();

      // zero denominator: w = 1 - u/4 vanishes at u = 4
      write_coef(IDX_WU, COEF_W'(-16384));
      write_coef(IDX_XC, 32'h0001_0000);
      write_coef(IDX_YC, 32'hFFFF_0000);
      write_coef(CSR_IDX_W'(99), 32'h1234_5678);
      send_pixel(12'd4, 12'd0);
      send_pixel(12'd3, 12'd0);
      send_pixel(12'd5, 12'd7);
      send_pixel(12'd4095, 12'd4095);
      drain();

      // saturation both ways, plus one coordinate clean while the other clamps
      write_coef(IDX_WU, '0);
      write_coef(IDX_WV, '0);
      write_coef(IDX_XU, POS_MAX);
      write_coef(IDX_XV, POS_MAX);
      write_coef(IDX_YU, NEG_MIN);
      write_coef(IDX_YV, '0);
      write_coef(IDX_YC, '0);
      send_pixel(12'd4095, 12'd4095);
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd1, 12'd0);
      send_pixel(12'd0, 12'd1);
      drain();
      write_coef(IDX_XC, NEG_MIN);
      send_pixel(12'd0, 12'd0);
      drain();

      // random phases, each with its own homography
      for (int ph = 0; ph < 12; ph++) begin
         for (int i = 0; i < NUM_COEF; i++) begin
            c = rand_coef(int'($urandom_range(3)));
            write_coef(CSR_IDX_W'(i), c);
         end
         // keep w near zero for some phases so the zero case comes up
         if (ph % 4 == 1) begin
            write_coef(IDX_WU, COEF_W'(-65536 / (int'($urandom_range(7)) + 1)));
            write_coef(IDX_WV, '0);
         end
         busy_mode = (ph == 5);
         for (int n = 0; n < 155; n++) begin
            if (ph % 4 == 1)
               send_pixel(PIXEL_BITS'($urandom_range(9)), PIXEL_BITS'($urandom_range(3)));
            else if ($urandom_range(3) == 0)
               send_pixel(PIXEL_BITS'($urandom_range(15)), PIXEL_BITS'($urandom_range(15)));
            else send_pixel(PIXEL_BITS'($urandom), PIXEL_BITS'($urandom));
         end
         drain();
      end
      busy_mode = 1'b0;

      if (fail_count == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

endmodule

### files.f
rtl/core/p2g_pkg.sv
rtl/core/p2g_div.sv
rtl/core/pixel_to_ground_plane_map.sv
rtl/core/p2g_checker.sv
tb/ground_map_checker.sv
tb/tb.sv
